// File: src/fpr_pkg.sv
// Shared types and constants for the Fermat primality round core.
package fpr_pkg;

	localparam int NUM_WIDTH_DEF = 62;
	localparam int FIELD_W       = 62;
	localparam int S_TDATA_W     = 128;
	localparam int M_TDATA_W     = 64;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV,
		OP_DIV_END,
		OP_MUL_SQ,
		OP_MUL_BASE,
		OP_MUL_STEP,
		OP_MUL_END,
		OP_EXP_SHIFT,
		OP_FINISH,
		OP_SHORT
	} op_t;

	typedef struct packed {
		logic short_cut;
		logic exp_msb;
	} status_t;

endpackage

// File: src/fpr_dp.sv
// Datapath: reduction, modular double-and-add multiplier, power and result registers.
module fpr_dp #(
	parameter int W = fpr_pkg::NUM_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic [fpr_pkg::FIELD_W-1:0] candidate,
	input  logic [fpr_pkg::FIELD_W-1:0] witness_base,
	input  fpr_pkg::op_t               op,
	output fpr_pkg::status_t           status,
	output logic                       verdict,
	output logic [fpr_pkg::FIELD_W-1:0] power_residue
);
	import fpr_pkg::*;

	logic [W-1:0] n_q, base_q, exp_q, pacc_q, macc_q, mx_q, my_q;
	logic [W:0]   rem_shift, rem_next;
	logic [W:0]   dbl, dbl_red, sum, sum_red;
	logic [W-1:0] step_val;

	// restoring remainder step, one dividend bit per cycle
	assign rem_shift = {macc_q, my_q[W-1]};
	assign rem_next  = (rem_shift >= {1'b0, n_q}) ? rem_shift - {1'b0, n_q} : rem_shift;

	// double, reduce, then conditionally add multiplicand and reduce
	assign dbl      = {macc_q, 1'b0};
	assign dbl_red  = (dbl >= {1'b0, n_q}) ? dbl - {1'b0, n_q} : dbl;
	assign sum      = {1'b0, dbl_red[W-1:0]} + {1'b0, mx_q};
	assign sum_red  = (sum >= {1'b0, n_q}) ? sum - {1'b0, n_q} : sum;
	assign step_val = my_q[W-1] ? sum_red[W-1:0] : dbl_red[W-1:0];

	assign status.short_cut = (n_q < W'(4)) || !n_q[0];
	assign status.exp_msb   = exp_q[W-1];

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				n_q    <= candidate[W-1:0];
				my_q   <= witness_base[W-1:0];
				exp_q  <= candidate[W-1:0] - W'(1);
				macc_q <= '0;
				pacc_q <= W'(1);
			end
			OP_DIV: begin
				macc_q <= rem_next[W-1:0];
				my_q   <= my_q << 1;
			end
			OP_DIV_END: begin
				base_q <= macc_q;
			end
			OP_MUL_SQ: begin
				mx_q   <= pacc_q;
				my_q   <= pacc_q;
				macc_q <= '0;
			end
			OP_MUL_BASE: begin
				mx_q   <= pacc_q;
				my_q   <= base_q;
				macc_q <= '0;
			end
			OP_MUL_STEP: begin
				macc_q <= step_val;
				my_q   <= my_q << 1;
			end
			OP_MUL_END: begin
				pacc_q <= macc_q;
			end
			OP_EXP_SHIFT: begin
				exp_q <= exp_q << 1;
			end
			OP_FINISH: begin
				verdict       <= (pacc_q == W'(1));
				power_residue <= FIELD_W'(pacc_q);
			end
			OP_SHORT: begin
				verdict       <= (n_q == W'(2)) || (n_q == W'(3));
				power_residue <= '0;
			end
			default: begin
			end
		endcase
	end

endmodule

// File: src/fpr_ctrl.sv
// Controller: sequences reduction, square-and-multiply and result hand-off.
module fpr_ctrl #(
	parameter int W = fpr_pkg::NUM_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  fpr_pkg::status_t status,
	output fpr_pkg::op_t     op
);
	import fpr_pkg::*;

	localparam int CW = (W > 1) ? $clog2(W) : 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLASS,
		ST_DIV,
		ST_DIV_END,
		ST_SQ_SETUP,
		ST_MUL_SETUP,
		ST_MUL_RUN,
		ST_MUL_END,
		ST_EXP_NEXT,
		ST_DONE,
		ST_SHORT
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q, ecnt_q;
	logic          sq_phase_q;
	logic          out_valid_q;
	logic          out_free;
	logic          out_load;

	assign out_free  = !out_valid_q || out_ready;
	assign out_load  = ((state_q == ST_DONE) || (state_q == ST_SHORT)) && out_free;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		op = OP_NONE;
		case (state_q)
			ST_IDLE:      op = in_valid ? OP_LOAD : OP_NONE;
			ST_DIV:       op = OP_DIV;
			ST_DIV_END:   op = OP_DIV_END;
			ST_SQ_SETUP:  op = OP_MUL_SQ;
			ST_MUL_SETUP: op = OP_MUL_BASE;
			ST_MUL_RUN:   op = OP_MUL_STEP;
			ST_MUL_END:   op = OP_MUL_END;
			ST_EXP_NEXT:  op = OP_EXP_SHIFT;
			ST_DONE:      op = out_free ? OP_FINISH : OP_NONE;
			ST_SHORT:     op = out_free ? OP_SHORT : OP_NONE;
			default:      op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			ecnt_q      <= '0;
			sq_phase_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result refills the slot in the same cycle the old one leaves
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_CLASS;
				end
				ST_CLASS: begin
					cnt_q   <= CW'(W - 1);
					state_q <= status.short_cut ? ST_SHORT : ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == '0)
						state_q <= ST_DIV_END;
				end
				ST_DIV_END: begin
					ecnt_q  <= CW'(W - 1);
					state_q <= ST_SQ_SETUP;
				end
				ST_SQ_SETUP: begin
					cnt_q      <= CW'(W - 1);
					sq_phase_q <= 1'b1;
					state_q    <= ST_MUL_RUN;
				end
				ST_MUL_SETUP: begin
					cnt_q      <= CW'(W - 1);
					sq_phase_q <= 1'b0;
					state_q    <= ST_MUL_RUN;
				end
				ST_MUL_RUN: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == '0)
						state_q <= ST_MUL_END;
				end
				ST_MUL_END: begin
					state_q <= (sq_phase_q && status.exp_msb) ? ST_MUL_SETUP : ST_EXP_NEXT;
				end
				ST_EXP_NEXT: begin
					ecnt_q <= ecnt_q - CW'(1);
					state_q <= (ecnt_q == '0) ? ST_DONE : ST_SQ_SETUP;
				end
				ST_DONE, ST_SHORT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: src/fermat_primality_round_core.sv
// Top level of the Fermat primality round core: one round per request.
//
//  channel | direction | tdata fields (low bit first)                 | tuser
//  s_*     | in        | candidate[61:0], witness_base[123:62], pad   | none
//  m_*     | out       | verdict[0], power_residue[62:1], pad         | none
//
//  Flow: a request with candidate below 4 or even goes from classification straight to
//  the short-cut result, and the core is ready again once that result is registered.
//  Otherwise the base is first reduced modulo the candidate (one remainder bit per
//  cycle), then each of NUM_WIDTH exponent bits costs a squaring plus a multiplication
//  by the base when the bit of candidate-1 is set; squarings and multiplications share
//  one double-and-add unit, one multiplier bit per cycle.
//  Reset clears only control state. One request is in work at a time; a new
//  request is taken while a finished result still waits in the output register.
module fermat_primality_round_core #(
	parameter int NUM_WIDTH = fpr_pkg::NUM_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [fpr_pkg::S_TDATA_W-1:0] s_tdata,   // candidate, witness_base
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [fpr_pkg::M_TDATA_W-1:0] m_tdata    // verdict, power_residue
);
	import fpr_pkg::*;

	op_t                op;
	status_t            status;
	logic               verdict;
	logic [FIELD_W-1:0] power_residue;

	// sequencer: reduce base, then square-and-multiply over candidate-1
	fpr_ctrl #(
		.W(NUM_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.status   (status),
		.op       (op)
	);

	// operand, accumulator and result registers; operands masked to NUM_WIDTH
	fpr_dp #(
		.W(NUM_WIDTH)
	) u_dp (
		.clk          (clk),
		.candidate    (s_tdata[FIELD_W-1:0]),
		.witness_base (s_tdata[2*FIELD_W-1:FIELD_W]),
		.op           (op),
		.status       (status),
		.verdict      (verdict),
		.power_residue(power_residue)
	);

	assign m_tdata = {{(M_TDATA_W - FIELD_W - 1){1'b0}}, power_residue, verdict};

	// a request is never taken back to back: the core leaves idle after accepting
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("core still idle after accepting a request");

	// a probable-prime verdict goes with residue 1, or 0 for the small-prime shortcut
	a_verdict_residue: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> (m_tdata[FIELD_W:1] == FIELD_W'(1)) ||
			(m_tdata[FIELD_W:1] == '0))
		else $error("prime verdict with unexpected residue");

	// a fresh result only appears after the core was busy with work
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result produced while idle");

endmodule
